>>> hw/rtl/twif_pkg.sv
// Shared types, constants and factor tables for the trade window impact factors unit
`timescale 1ns / 1ps
package twif_pkg;

    localparam int DEF_HISTORY_DEPTH = 256;
    localparam int DEF_PRICE_BITS    = 32;
    localparam int DEF_VOLUME_BITS   = 32;

    localparam int NUM_FACTORS = 12;
    localparam int FACTOR_W    = 4;
    localparam int VALUE_W     = 48;
    localparam int QUOT_W      = 48;
    localparam int NUM_WINDOWS = 4;
    // deepest age any window reaches is lag 2 plus 128 trades
    localparam int SCAN_AGES   = 130;
    localparam int OFI_W       = 40;

    localparam logic [FACTOR_W-1:0] LAST_INDEX = FACTOR_W'(NUM_FACTORS - 1);
    localparam logic [OFI_W-1:0]    OFI_RATIO  = 40'd1000000000000;

    localparam logic       ACT_ADD    = 1'b0;
    localparam logic       ACT_UPDATE = 1'b1;
    localparam logic [1:0] SIDE_BUY   = 2'd0;
    localparam logic [1:0] SIDE_SELL  = 2'd1;

    localparam int WIN_LEN [NUM_WINDOWS] = '{16, 32, 64, 128};
    localparam int WIN_LAG [NUM_WINDOWS] = '{0, 0, 1, 2};

    typedef enum logic [1:0] {
        KIND_IMPACT,
        KIND_MID,
        KIND_OFI,
        KIND_ABSORB
    } kind_t;

    typedef enum logic [1:0] {
        JOB_OFI,
        JOB_NUM,
        JOB_DEN,
        JOB_DEN2
    } mul_job_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_WRITE,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_LOAD,
        OP_MUL_START,
        OP_MUL_STEP,
        OP_MUL_STORE,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        mul_job_t            job;
        logic [FACTOR_W-1:0] fidx;
        logic                zero;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic mul_done;
        logic div_done;
        logic short_win;
        logic ofi_zero;
        logic out_free;
    } dp_status_t;

    function automatic kind_t fac_kind(input logic [FACTOR_W-1:0] idx);
        kind_t k;
        case (idx)
            4'd0, 4'd1, 4'd2, 4'd3: k = KIND_IMPACT;
            4'd4, 4'd5, 4'd6, 4'd7: k = KIND_MID;
            4'd8, 4'd9:             k = KIND_OFI;
            default:                k = KIND_ABSORB;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] fac_win(input logic [FACTOR_W-1:0] idx);
        logic [1:0] w;
        if (idx < 4'd8)
            w = idx[1:0];
        else
            w = {1'b0, idx[0]};
        return w;
    endfunction

endpackage

>>> hw/rtl/twif_in_if.sv
// Input channel: trade records and update requests
`timescale 1ns / 1ps
interface twif_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic        trade_cancel;
    logic [31:0] price;
    logic [31:0] volume;
    logic [1:0]  trade_side;

    modport source (output valid, action, trade_cancel, price, volume, trade_side,
                    input ready);
    modport sink   (input valid, action, trade_cancel, price, volume, trade_side,
                    output ready);
endinterface

>>> hw/rtl/twif_out_if.sv
// Output channel: one factor per transfer
`timescale 1ns / 1ps
interface twif_out_if;
    import twif_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [FACTOR_W-1:0]       factor_index;
    logic signed [VALUE_W-1:0] factor_value;
    logic                      last_factor;

    modport source (output valid, factor_index, factor_value, last_factor, input ready);
    modport sink   (input valid, factor_index, factor_value, last_factor, output ready);
endinterface

>>> hw/rtl/twif_datapath.sv
// Datapath: trade rings, window scan, serial multiplier, restoring divider, output register
`timescale 1ns / 1ps
module twif_datapath #(
    parameter int HISTORY_DEPTH = twif_pkg::DEF_HISTORY_DEPTH,
    parameter int PRICE_BITS    = twif_pkg::DEF_PRICE_BITS,
    parameter int VOLUME_BITS   = twif_pkg::DEF_VOLUME_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  twif_pkg::dp_cmd_t    cmd,
    output twif_pkg::dp_status_t status,
    input  logic                 trade_cancel,
    input  logic [31:0]          price,
    input  logic [31:0]          volume,
    input  logic [1:0]           trade_side,
    twif_out_if.source           out_ch
);
    import twif_pkg::*;

    localparam int PW    = PRICE_BITS;
    localparam int VW    = VOLUME_BITS;
    localparam int SW    = PW + 1;
    localparam int AW    = VW + 8;
    localparam int NW    = AW + 1;
    localparam int BW    = 2 * SW + AW + 36;
    localparam int MB0   = (AW > SW) ? AW : SW;
    localparam int MB    = (MB0 > OFI_W) ? MB0 : OFI_W;
    localparam int MCW   = $clog2(MB + 1);
    localparam int DW    = BW + 50;
    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int AGE_W = $clog2(SCAN_AGES + 2);
    localparam int QCW   = $clog2(QUOT_W + 1);

    // ring storage
    logic [PW-1:0]        price_mem [HISTORY_DEPTH];
    logic signed [VW:0]   vol_mem   [HISTORY_DEPTH];
    logic [PTR_W-1:0]     wp_reg, wp_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic [PW-1:0]        price_in;
    logic [VW-1:0]        vol_in;
    logic signed [VW:0]   vol_pos, vol_signed;
    logic                 wr_en;

    assign price_in   = PW'(price);
    assign vol_in     = VW'(volume);
    assign vol_pos    = signed'({1'b0, vol_in});
    assign vol_signed = (trade_side == SIDE_BUY) ? vol_pos : -vol_pos;
    assign wr_en      = (cmd.op == OP_WRITE) && !trade_cancel && (price_in != '0)
                        && (vol_in != '0) && (trade_side == SIDE_BUY || trade_side == SIDE_SELL);

    always_comb
    begin
        wp_next  = wp_reg;
        cnt_next = cnt_reg;
        if (wr_en)
        begin
            wp_next = (wp_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (cnt_reg != CNT_W'(HISTORY_DEPTH))
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            price_mem[wp_reg] <= price_in;
            vol_mem[wp_reg]   <= vol_signed;
        end
    end

    // scan: ages 0 (newest) upward, one read a cycle
    logic [AGE_W-1:0]   age_reg, dage_reg;
    logic               dvld_reg;
    logic               issue;
    logic [PTR_W:0]     slot_full;
    logic [PTR_W-1:0]   rd_addr;
    logic [PW-1:0]      rd_price_reg;
    logic signed [VW:0] rd_vol_reg;
    logic [VW:0]        rd_vol_abs;

    assign issue     = (cmd.op == OP_SCAN) && (age_reg < AGE_W'(SCAN_AGES));
    assign slot_full = (PTR_W+1)'(wp_reg) + (PTR_W+1)'(HISTORY_DEPTH - 1) - (PTR_W+1)'(age_reg);
    assign rd_addr   = (slot_full >= (PTR_W+1)'(HISTORY_DEPTH))
                       ? PTR_W'(slot_full - (PTR_W+1)'(HISTORY_DEPTH)) : PTR_W'(slot_full);
    assign rd_vol_abs = rd_vol_reg[VW] ? (VW+1)'(-rd_vol_reg) : (VW+1)'(rd_vol_reg);

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_price_reg <= price_mem[rd_addr];
            rd_vol_reg   <= vol_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg  <= '0;
            dage_reg <= '0;
            dvld_reg <= 1'b0;
        end
        else if (cmd.op == OP_SCAN_INIT)
        begin
            age_reg  <= '0;
            dvld_reg <= 1'b0;
        end
        else if (cmd.op == OP_SCAN)
        begin
            dvld_reg <= issue;
            dage_reg <= age_reg;
            if (age_reg != AGE_W'(SCAN_AGES + 1))
                age_reg <= age_reg + 1'b1;
        end
    end

    // per-window counts and running sums
    logic [CNT_W:0]       wcnt [NUM_WINDOWS];
    logic signed [NW-1:0] net_reg   [NUM_WINDOWS];
    logic [AW-1:0]        abs_reg   [NUM_WINDOWS];
    logic [PW-1:0]        first_reg [NUM_WINDOWS];
    logic [PW-1:0]        last_reg  [NUM_WINDOWS];
    logic [CNT_W:0]       dage_ext;

    assign dage_ext = (CNT_W+1)'(dage_reg);

    always_comb
    begin
        for (int w = 0; w < NUM_WINDOWS; w++)
        begin
            if ({1'b0, cnt_reg} > (CNT_W+1)'(WIN_LAG[w]))
            begin
                wcnt[w] = {1'b0, cnt_reg} - (CNT_W+1)'(WIN_LAG[w]);
                if (wcnt[w] > (CNT_W+1)'(WIN_LEN[w]))
                    wcnt[w] = (CNT_W+1)'(WIN_LEN[w]);
            end
            else
                wcnt[w] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int w = 0; w < NUM_WINDOWS; w++)
        begin
            if (cmd.op == OP_SCAN_INIT)
            begin
                net_reg[w] <= '0;
                abs_reg[w] <= '0;
            end
            else if (cmd.op == OP_SCAN && dvld_reg)
            begin
                if (dage_ext >= (CNT_W+1)'(WIN_LAG[w])
                    && dage_ext < (CNT_W+1)'(WIN_LAG[w]) + wcnt[w])
                begin
                    net_reg[w] <= net_reg[w] + NW'(rd_vol_reg);
                    abs_reg[w] <= abs_reg[w] + AW'(rd_vol_abs);
                end
                if (dage_ext == (CNT_W+1)'(WIN_LAG[w]))
                    last_reg[w] <= rd_price_reg;
                if (dage_ext == (CNT_W+1)'(WIN_LAG[w]) + wcnt[w] - 1'b1)
                    first_reg[w] <= rd_price_reg;
            end
        end
    end

    // operands of the selected factor
    logic [1:0]           wsel;
    kind_t                kind_sel, kind_reg;
    logic signed [NW-1:0] net_sel;
    logic [AW-1:0]        abs_sel, an_c, a1_c;
    logic [PW-1:0]        first_sel, last_sel, ad_c;
    logic [SW-1:0]        s_c, s2_c, ad2_c, ae_c;
    logic                 nneg_c, dneg_c, eneg_c;

    logic [AW-1:0] an_reg, a1_reg;
    logic [PW-1:0] ad_reg;
    logic [SW-1:0] s_reg, ae_reg;
    logic          neg_reg, short_reg;

    always_comb
    begin
        wsel      = fac_win(cmd.fidx);
        kind_sel  = fac_kind(cmd.fidx);
        net_sel   = net_reg[wsel];
        abs_sel   = abs_reg[wsel];
        first_sel = first_reg[wsel];
        last_sel  = last_reg[wsel];
        nneg_c    = net_sel < 0;
        an_c      = nneg_c ? AW'(-net_sel) : AW'(net_sel);
        a1_c      = (abs_sel == '0) ? AW'(1) : abs_sel;
        s_c       = SW'(first_sel) + SW'(last_sel);
        s2_c      = (s_c < SW'(2)) ? SW'(2) : s_c;
        dneg_c    = last_sel < first_sel;
        ad_c      = dneg_c ? first_sel - last_sel : last_sel - first_sel;
        ad2_c     = {ad_c, 1'b0};
        eneg_c    = ad2_c > s2_c;
        ae_c      = eneg_c ? ad2_c - s2_c : s2_c - ad2_c;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            kind_reg  <= kind_sel;
            an_reg    <= an_c;
            a1_reg    <= a1_c;
            s_reg     <= s2_c;
            ad_reg    <= ad_c;
            ae_reg    <= ae_c;
            neg_reg   <= (kind_sel == KIND_ABSORB) ? (nneg_c ^ eneg_c) : (dneg_c ^ nneg_c);
            short_reg <= wcnt[wsel] < (CNT_W+1)'(2);
        end
    end

    // shift-add multiplier, one multiplier bit a cycle
    logic [BW-1:0]  mcand_reg, prod_reg, num_reg, den_reg;
    logic [MB-1:0]  mplier_reg;
    logic [MCW-1:0] mcnt_reg;
    logic           ofi_zero_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_MUL_START:
            begin
                prod_reg <= '0;
                mcnt_reg <= '0;
                case (cmd.job)
                    JOB_OFI:
                    begin
                        mcand_reg  <= BW'(an_reg);
                        mplier_reg <= MB'(OFI_RATIO);
                    end
                    JOB_NUM:
                    begin
                        if (kind_reg == KIND_ABSORB)
                        begin
                            mcand_reg  <= BW'(an_reg);
                            mplier_reg <= MB'(ae_reg);
                        end
                        else if (kind_reg == KIND_OFI)
                        begin
                            mcand_reg  <= BW'(ad_reg);
                            mplier_reg <= MB'(a1_reg);
                        end
                        else
                        begin
                            mcand_reg  <= BW'(ad_reg);
                            mplier_reg <= MB'(an_reg);
                        end
                    end
                    JOB_DEN:
                    begin
                        mcand_reg <= BW'(s_reg);
                        if (kind_reg == KIND_MID)
                            mplier_reg <= MB'(s_reg);
                        else if (kind_reg == KIND_OFI)
                            mplier_reg <= MB'(an_reg);
                        else
                            mplier_reg <= MB'(a1_reg);
                    end
                    default:
                    begin
                        mcand_reg  <= den_reg;
                        mplier_reg <= MB'(a1_reg);
                    end
                endcase
            end
            OP_MUL_STEP:
            begin
                if (mplier_reg[0])
                    prod_reg <= prod_reg + mcand_reg;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                mcnt_reg   <= mcnt_reg + 1'b1;
            end
            OP_MUL_STORE:
            begin
                case (cmd.job)
                    JOB_OFI: ofi_zero_reg <= prod_reg <= BW'(a1_reg);
                    JOB_NUM:
                    begin
                        case (kind_reg)
                            KIND_MID:    num_reg <= prod_reg << 34;
                            KIND_ABSORB: num_reg <= prod_reg << 32;
                            default:     num_reg <= prod_reg << 33;
                        endcase
                    end
                    default: den_reg <= prod_reg;
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // rounded quotient (2*num + den) / (2*den), one bit a cycle
    logic [DW-1:0]     n2_c, rem_reg, dsh_reg;
    logic [QUOT_W-1:0] q_reg;
    logic [QCW-1:0]    dcnt_reg;
    logic              huge_reg;
    logic              ge_c;

    assign n2_c = DW'({num_reg, 1'b0}) + DW'(den_reg);
    assign ge_c = rem_reg >= dsh_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_DIV_INIT)
        begin
            huge_reg <= n2_c >= (DW'(den_reg) << (QUOT_W + 1));
            rem_reg  <= n2_c;
            dsh_reg  <= DW'(den_reg) << QUOT_W;
            q_reg    <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.op == OP_DIV_STEP)
        begin
            if (ge_c)
                rem_reg <= rem_reg - dsh_reg;
            q_reg    <= {q_reg[QUOT_W-2:0], ge_c};
            dsh_reg  <= dsh_reg >> 1;
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    // saturation and output register
    logic [VALUE_W-1:0] limit_c, mag_c, val_c;
    logic               out_valid_reg;
    logic [FACTOR_W-1:0] out_idx_reg;
    logic [VALUE_W-1:0] out_val_reg;
    logic               out_last_reg;

    always_comb
    begin
        limit_c = neg_reg ? (VALUE_W'(1) << (VALUE_W - 1)) : ((VALUE_W'(1) << (VALUE_W - 1)) - 1'b1);
        mag_c   = (huge_reg || q_reg > limit_c) ? limit_c : q_reg;
        val_c   = cmd.zero ? '0 : (neg_reg ? -mag_c : mag_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_OUT)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_OUT)
        begin
            out_idx_reg  <= cmd.fidx;
            out_val_reg  <= val_c;
            out_last_reg <= cmd.fidx == LAST_INDEX;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.factor_index = out_idx_reg;
    assign out_ch.factor_value = signed'(out_val_reg);
    assign out_ch.last_factor  = out_last_reg;

    assign status.scan_done = age_reg == AGE_W'(SCAN_AGES + 1);
    assign status.mul_done  = mcnt_reg == MCW'(MB);
    assign status.div_done  = dcnt_reg == QCW'(QUOT_W);
    assign status.short_win = short_reg;
    assign status.ofi_zero  = ofi_zero_reg;
    assign status.out_free  = !out_valid_reg || out_ch.ready;

endmodule

>>> hw/rtl/twif_ctrl.sv
// Controller: sequences the scan and the per-factor multiply and divide steps
`timescale 1ns / 1ps
module twif_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_action,
    output logic                 in_ready,
    output twif_pkg::dp_cmd_t    cmd,
    input  twif_pkg::dp_status_t status
);
    import twif_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_INIT,
        S_SCAN,
        S_LOAD,
        S_CHK,
        S_MSTART,
        S_MRUN,
        S_OFICHK,
        S_DIVINIT,
        S_DIV,
        S_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [FACTOR_W-1:0] fidx_reg, fidx_next;
    mul_job_t            job_reg, job_next;
    logic                zero_reg, zero_next;
    kind_t               kind;

    assign kind     = fac_kind(fidx_reg);
    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        fidx_next  = fidx_reg;
        job_next   = job_reg;
        zero_next  = zero_reg;
        cmd.op     = OP_NONE;
        cmd.job    = job_reg;
        cmd.fidx   = fidx_reg;
        cmd.zero   = zero_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_action == ACT_UPDATE)
                        state_next = S_SCAN_INIT;
                    else
                        cmd.op = OP_WRITE;
                end
            end
            S_SCAN_INIT:
            begin
                cmd.op     = OP_SCAN_INIT;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (status.scan_done)
                begin
                    fidx_next  = '0;
                    state_next = S_LOAD;
                end
                else
                    cmd.op = OP_SCAN;
            end
            S_LOAD:
            begin
                cmd.op     = OP_LOAD;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                zero_next = status.short_win;
                if (status.short_win)
                    state_next = S_OUT;
                else
                begin
                    job_next   = (kind == KIND_OFI) ? JOB_OFI : JOB_NUM;
                    state_next = S_MSTART;
                end
            end
            S_MSTART:
            begin
                cmd.op     = OP_MUL_START;
                state_next = S_MRUN;
            end
            S_MRUN:
            begin
                if (!status.mul_done)
                    cmd.op = OP_MUL_STEP;
                else
                begin
                    cmd.op = OP_MUL_STORE;
                    unique case (job_reg)
                        JOB_OFI: state_next = S_OFICHK;
                        JOB_NUM:
                        begin
                            job_next   = JOB_DEN;
                            state_next = S_MSTART;
                        end
                        JOB_DEN:
                        begin
                            if (kind == KIND_MID)
                            begin
                                job_next   = JOB_DEN2;
                                state_next = S_MSTART;
                            end
                            else
                                state_next = S_DIVINIT;
                        end
                        JOB_DEN2: state_next = S_DIVINIT;
                    endcase
                end
            end
            S_OFICHK:
            begin
                if (status.ofi_zero)
                begin
                    zero_next  = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    job_next   = JOB_NUM;
                    state_next = S_MSTART;
                end
            end
            S_DIVINIT:
            begin
                cmd.op     = OP_DIV_INIT;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_OUT;
                else
                    cmd.op = OP_DIV_STEP;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op = OP_OUT;
                    if (fidx_reg == LAST_INDEX)
                        state_next = S_IDLE;
                    else
                    begin
                        fidx_next  = fidx_reg + 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fidx_reg  <= '0;
            job_reg   <= JOB_NUM;
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fidx_reg  <= fidx_next;
            job_reg   <= job_next;
            zero_reg  <= zero_next;
        end
    end

endmodule

>>> hw/rtl/trade_window_impact_factors_unit.sv
// Trade add: the record is written as it is taken; a new transfer may follow in the next cycle.
// Update: a window scan (one ring read a cycle), then per factor bit-serial products and a
// restoring divider for impact, absorption, mid and ofi factors; an ofi factor with near-zero
// imbalance stops after its first product, and a short window skips both.
// Results leave through an output register; a new record is taken while the last waits.
// Reset (rst_n, asynchronous, active low) empties the ring and clears all control state.
`timescale 1ns / 1ps
module trade_window_impact_factors_unit #(
    parameter int HISTORY_DEPTH = twif_pkg::DEF_HISTORY_DEPTH,
    parameter int PRICE_BITS    = twif_pkg::DEF_PRICE_BITS,
    parameter int VOLUME_BITS   = twif_pkg::DEF_VOLUME_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    twif_in_if.sink    in_ch,
    twif_out_if.source out_ch
);
    import twif_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    twif_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_action (in_ch.action),
        .in_ready  (in_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    twif_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PRICE_BITS    (PRICE_BITS),
        .VOLUME_BITS   (VOLUME_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .trade_cancel (in_ch.trade_cancel),
        .price        (in_ch.price),
        .volume       (in_ch.volume),
        .trade_side   (in_ch.trade_side),
        .out_ch       (out_ch)
    );

endmodule

>>> hw/rtl/twif_checker.sv
// Port-level checks on the trade window impact factors unit, bound to the top level
`timescale 1ns / 1ps
module twif_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_action,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  out_index,
    input logic [47:0] out_value,
    input logic        out_last
);
    import twif_pkg::*;

    a_busy_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_action == ACT_UPDATE) |=> !in_ready)
        else $error("input taken straight after an update transfer");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_index <= LAST_INDEX)
        else $error("factor index out of range");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_last == (out_index == LAST_INDEX)))
        else $error("last flag does not match factor index");

    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_last) |=> !out_valid || out_index == $past(out_index) + 4'd1)
        else $error("factors out of order");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_value) && $stable(out_index))
        else $error("stalled result changed");

endmodule

bind trade_window_impact_factors_unit twif_checker u_twif_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_action (in_ch.action),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_index (out_ch.factor_index),
    .out_value (out_ch.factor_value),
    .out_last  (out_ch.last_factor)
);

>>> tb/sv/tb_trade_window_impact_factors_unit.sv
// Self-checking testbench for the trade window impact factors unit
`timescale 1ns / 1ps
module tb_trade_window_impact_factors_unit;
    import twif_pkg::*;

    localparam int          RING        = 256;
    localparam int          RAND_ITEMS  = 385;
    localparam int          CYCLE_LIMIT = 4000000;
    localparam logic [1:0]  SIDE_NONE   = 2'd2;
    localparam logic [1:0]  SIDE_BAD    = 2'd3;

    typedef struct {
        logic        action;
        logic        cancel;
        logic [31:0] price;
        logic [31:0] volume;
        logic [1:0]  side;
    } trade_item_t;

    typedef struct {
        logic [FACTOR_W-1:0] idx;
        logic [VALUE_W-1:0]  value;
        logic                last;
    } factor_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    twif_in_if  in_ch();
    twif_out_if out_ch();

    trade_window_impact_factors_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #10 clk = ~clk;

    trade_item_t pending_trades[$];
    factor_t     expected_factors[$];
    trade_item_t cur_item;
    int          sent_count;
    int          mismatches;
    int          cycles;

    // predictor state
    logic [31:0] price_hist[RING];
    longint      vol_hist[RING];
    int          hist_count;
    logic [7:0]  hist_wr;

    kind_t tab_kind[NUM_FACTORS] = '{KIND_IMPACT, KIND_IMPACT, KIND_IMPACT, KIND_IMPACT,
                                     KIND_MID, KIND_MID, KIND_MID, KIND_MID,
                                     KIND_OFI, KIND_OFI, KIND_ABSORB, KIND_ABSORB};
    int    tab_win[NUM_FACTORS]  = '{16, 32, 64, 128, 16, 32, 64, 128, 16, 32, 16, 32};
    int    tab_lag[NUM_FACTORS]  = '{0, 0, 1, 2, 0, 0, 1, 2, 0, 0, 0, 0};

    function automatic logic [VALUE_W-1:0] round_sat(logic [255:0] num, logic [255:0] den,
                                                     logic neg);
        logic [255:0] q;
        logic [63:0]  mag;
        logic [63:0]  lim;
        q   = ((num << 1) + den) / (den << 1);
        lim = neg ? (64'd1 << 47) : ((64'd1 << 47) - 64'd1);
        mag = (q > {192'd0, lim}) ? lim : q[63:0];
        mag = neg ? (64'd0 - mag) : mag;
        return mag[VALUE_W-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] window_factor(kind_t kind, int win, int lag);
        int           cnt;
        longint       net;
        longint       v;
        logic [63:0]  absv, a1, s, ad, an, ae, first, lastp;
        logic         dneg, nneg, eneg;
        logic [255:0] num, den;
        logic [7:0]   slot;
        if (hist_count <= lag)
            return '0;
        cnt = (hist_count - lag > win) ? win : hist_count - lag;
        if (cnt < 2)
            return '0;
        net  = 0;
        absv = 0;
        for (int k = 0; k < cnt; k++)
        begin
            slot = hist_wr - 8'd1 - 8'(lag + k);
            v    = vol_hist[slot];
            net  += v;
            absv += (v < 0) ? 64'(-v) : 64'(v);
        end
        slot  = hist_wr - 8'd1 - 8'(lag + cnt - 1);
        first = {32'd0, price_hist[slot]};
        slot  = hist_wr - 8'd1 - 8'(lag);
        lastp = {32'd0, price_hist[slot]};
        a1    = (absv != 0) ? absv : 64'd1;
        s     = first + lastp;
        if (s < 2)
            s = 2;
        dneg = lastp < first;
        ad   = dneg ? first - lastp : lastp - first;
        nneg = net < 0;
        an   = nneg ? 64'(-net) : 64'(net);
        case (kind)
            KIND_IMPACT:
            begin
                num = ({192'd0, ad} * {192'd0, an}) << 33;
                den = {192'd0, s} * {192'd0, a1};
                return round_sat(num, den, dneg != nneg);
            end
            KIND_MID:
            begin
                num = ({192'd0, ad} * {192'd0, an}) << 34;
                den = {192'd0, s} * {192'd0, s} * {192'd0, a1};
                return round_sat(num, den, dneg != nneg);
            end
            KIND_OFI:
            begin
                if (an <= a1 / 64'd1000000000000)
                    return '0;
                num = ({192'd0, ad} * {192'd0, a1}) << 33;
                den = {192'd0, s} * {192'd0, an};
                return round_sat(num, den, dneg != nneg);
            end
            default:
            begin
                eneg = 2 * ad > s;
                ae   = eneg ? 2 * ad - s : s - 2 * ad;
                num  = ({192'd0, an} * {192'd0, ae}) << 32;
                den  = {192'd0, a1} * {192'd0, s};
                return round_sat(num, den, nneg != eneg);
            end
        endcase
    endfunction

    task automatic predict_trade(trade_item_t it);
        factor_t f;
        if (it.action == ACT_ADD)
        begin
            if (it.cancel || it.price == 0 || it.volume == 0 ||
                (it.side != SIDE_BUY && it.side != SIDE_SELL))
                return;
            price_hist[hist_wr] = it.price;
            vol_hist[hist_wr]   = (it.side == SIDE_BUY) ? longint'(it.volume)
                                                        : -longint'(it.volume);
            hist_wr = hist_wr + 8'd1;
            if (hist_count < RING)
                hist_count++;
        end
        else
        begin
            for (int k = 0; k < NUM_FACTORS; k++)
            begin
                f.idx   = FACTOR_W'(k);
                f.value = window_factor(tab_kind[k], tab_win[k], tab_lag[k]);
                f.last  = (k == NUM_FACTORS - 1);
                expected_factors.insert(expected_factors.size(), f);
            end
        end
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    function automatic int send_idle_pct(int n);
        int p;
        p = n * 4 / (RAND_ITEMS + 25);
        return (p == 1) ? 50 : (p >= 3) ? 37 : 0;
    endfunction

    function automatic int recv_stall_pct(int n);
        int p;
        p = n * 4 / (RAND_ITEMS + 25);
        return (p == 2) ? 50 : (p >= 3) ? 37 : 0;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_trade(cur_item);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_trades.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct(sent_count))
                begin
                    cur_item = pending_trades[0];
                    pending_trades.delete(0);
                    sent_count++;
                    in_ch.valid        <= 1'b1;
                    in_ch.action       <= cur_item.action;
                    in_ch.trade_cancel <= cur_item.cancel;
                    in_ch.price        <= cur_item.price;
                    in_ch.volume       <= cur_item.volume;
                    in_ch.trade_side   <= cur_item.side;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        factor_t f;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= $urandom_range(0, 99) >= recv_stall_pct(sent_count);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_factors.size() == 0)
                begin
                    report("unexpected factor", 64'(out_ch.factor_index), 64'(out_ch.factor_value));
                end
                else
                begin
                    f = expected_factors[0];
                    expected_factors.delete(0);
                    if (out_ch.factor_index !== f.idx)
                        report("factor_index", 64'(out_ch.factor_index), 64'(f.idx));
                    if (out_ch.factor_value !== f.value)
                        report("factor_value", 64'(out_ch.factor_value), 64'(f.value));
                    if (out_ch.last_factor !== f.last)
                        report("last_factor", 64'(out_ch.last_factor), 64'(f.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic push_item(logic act, logic cancel, logic [31:0] price, logic [31:0] vol,
                             logic [1:0] side);
        trade_item_t it;
        it.action = act;
        it.cancel = cancel;
        it.price  = price;
        it.volume = vol;
        it.side   = side;
        pending_trades.insert(pending_trades.size(), it);
    endtask

    initial
    begin
        logic [31:0] base;
        int          r;
        in_ch.valid        = 1'b0;
        in_ch.action       = ACT_ADD;
        in_ch.trade_cancel = 1'b0;
        in_ch.price        = '0;
        in_ch.volume       = '0;
        in_ch.trade_side   = SIDE_BUY;
        out_ch.ready       = 1'b0;
        sent_count = 0;
        mismatches = 0;
        cycles     = 0;
        hist_count = 0;
        hist_wr    = 8'd0;

        // empty ring, short window, dropped records
        push_item(ACT_UPDATE, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, SIDE_BAD);
        push_item(ACT_ADD, 1'b0, 32'd100, 32'd5, SIDE_BUY);
        push_item(ACT_UPDATE, 1'b0, 32'd0, 32'd0, SIDE_BUY);
        push_item(ACT_ADD, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, SIDE_BUY);
        push_item(ACT_ADD, 1'b0, 32'd0, 32'd7, SIDE_SELL);
        push_item(ACT_ADD, 1'b0, 32'd50, 32'd0, SIDE_BUY);
        push_item(ACT_ADD, 1'b0, 32'd50, 32'd9, SIDE_NONE);
        push_item(ACT_ADD, 1'b0, 32'd50, 32'd9, SIDE_BAD);
        // balanced flow: near-zero imbalance
        push_item(ACT_ADD, 1'b0, 32'd100, 32'd5, SIDE_SELL);
        push_item(ACT_UPDATE, 1'b0, 32'd0, 32'd0, SIDE_BUY);
        // extremes and positive saturation
        push_item(ACT_ADD, 1'b0, 32'd1, 32'hFFFFFFFF, SIDE_BUY);
        push_item(ACT_ADD, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFE, SIDE_SELL);
        push_item(ACT_UPDATE, 1'b0, 32'd0, 32'd0, SIDE_BUY);
        // falling price, negative saturation
        push_item(ACT_ADD, 1'b0, 32'd1, 32'd1, SIDE_BUY);
        push_item(ACT_UPDATE, 1'b0, 32'd0, 32'd0, SIDE_BUY);
        push_item(ACT_ADD, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, SIDE_SELL);
        push_item(ACT_ADD, 1'b0, 32'd2, 32'hFFFFFFFF, SIDE_BUY);
        push_item(ACT_UPDATE, 1'b0, 32'd0, 32'd0, SIDE_BUY);

        base = 32'd100000;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                push_item(ACT_UPDATE, 1'($urandom), $urandom, $urandom, 2'($urandom));
            else if (r < 16)
                push_item(ACT_ADD, 1'($urandom), ($urandom_range(0, 1) != 0) ? $urandom : 32'd0,
                          ($urandom_range(0, 1) != 0) ? $urandom : 32'd0, 2'($urandom));
            else if (r < 26)
                push_item(ACT_ADD, 1'b0, $urandom | 32'd1, $urandom | 32'd1,
                          2'($urandom_range(0, 1)));
            else
            begin
                if ($urandom_range(0, 30) == 0)
                    base = $urandom_range(2000, 32'hFFFF0000);
                base = base + $urandom_range(0, 200) - 100;
                push_item(ACT_ADD, 1'b0, base,
                          ($urandom_range(0, 3) == 0) ? $urandom | 32'd1
                                                      : $urandom_range(1, 1000),
                          2'($urandom_range(0, 1)));
            end
        end
        push_item(ACT_UPDATE, 1'b0, 32'd0, 32'd0, SIDE_BUY);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_trades.size() == 0 && !in_ch.valid);
        wait (expected_factors.size() == 0);
        repeat (2500) @(posedge clk);
        if (mismatches == 0 && expected_factors.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/twif_pkg.sv
hw/rtl/twif_in_if.sv
hw/rtl/twif_out_if.sv
hw/rtl/twif_datapath.sv
hw/rtl/twif_ctrl.sv
hw/rtl/trade_window_impact_factors_unit.sv
hw/rtl/twif_checker.sv
tb/sv/tb_trade_window_impact_factors_unit.sv
